### rtl/psk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the per-channel scalar Kalman filter.
// Holds the sequencer state type and the reset values of the process noise.
// Depends on nothing.
package psk_pkg;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_PREP = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_QWR  = 7'b1000000
  } state_e;

  localparam int unsigned QTAB_LEN = 16;

  // Default process noise per channel, in hundredths.
  localparam logic [11:0] Q_HUNDREDTHS [QTAB_LEN] = '{
    12'd2560, 12'd1746, 12'd1149, 12'd1558, 12'd2636, 12'd2774, 12'd2441, 12'd3396,
    12'd4014, 12'd2910, 12'd1245, 12'd1159, 12'd1290, 12'd1035, 12'd3754, 12'd2245
  };

  // Reset process noise of a channel in fixed point, rounded to nearest.
  function automatic logic [31:0] q_reset(input int unsigned idx, input int unsigned frac);
    logic [63:0] h;
    logic [63:0] v;
    h = 64'(Q_HUNDREDTHS[idx % QTAB_LEN]);
    v = ((h << frac) + 64'd50) / 64'd100;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

### rtl/psk_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module psk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/per_channel_scalar_kalman.sv
`timescale 1ns / 1ps
// Top level of the per-channel scalar Kalman filter: sequencer, gain divider,
// multipliers and two state memories. Depends on psk_pkg and psk_ram.

// A sample item (kind 0) keeps the block busy from the edge that accepts it
// through the load, prepare, divide, multiply and finish states; a new item
// can be taken only once busy is low again. The divide state runs the
// bit-serial gain divider, which resolves one quotient bit per cycle. The
// result appears on estimate_o and gain_o for exactly one cycle, marked by
// done_o, in the first cycle in which busy is low again; the receiver cannot
// stall it and must take it in that cycle. A noise item (kind 1) is a
// read-modify-write of the process noise memory; it keeps the block busy
// through the load and write states, and it gives no result. An item for a
// channel at or beyond CHANNELS is accepted and dropped without raising busy.
// The error covariance and process noise live in two small RAMs with a
// registered read; per-entry valid bits make an entry that has never been
// written read as its reset value, so no clearing pass is needed after
// reset. Because only one item is in flight, a write-back always completes
// before the next read of the same entry. The observation noise register
// may only be written while busy is low.
module per_channel_scalar_kalman import psk_pkg::*; #(
  parameter int unsigned CHANNELS  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [3:0]         channel_i,
  input  logic signed [15:0] raw_sample_i,
  input  logic signed [15:0] previous_estimate_i,
  input  logic [23:0]        noise_ratio_i,
  input  logic               noise_we_i,
  input  logic [31:0]        noise_wdata_i,
  output logic               done_o,
  output logic signed [15:0] estimate_o,
  output logic [16:0]        gain_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Gain width: FRAC_BITS fraction bits and one integer bit for exactly one.
  localparam int unsigned KW = FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(FRAC_BITS + 1);
  localparam int unsigned EW = KW + 18;
  localparam int unsigned PW = KW + 32;
  localparam logic [31:0]    ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic [KW-1:0]  ONE_K  = KW'(64'd1 << FRAC_BITS);

  state_e state_q, state_d;

  logic                 kind_q;
  logic [AW-1:0]        addr_q;
  logic signed [15:0]   raw_q;
  logic signed [15:0]   last_q;
  logic [23:0]          ratio_q;
  logic [31:0]          obs_q;
  logic [CHANNELS-1:0]  p_vld_q;
  logic [CHANNELS-1:0]  q_vld_q;
  logic [31:0]          pt_q;
  logic [32:0]          denom_q;
  logic                 dz_q;
  logic [33:0]          rem_q;
  logic [KW-1:0]        quo_q;
  logic [CW-1:0]        cnt_q;
  logic signed [EW-1:0] prod_e_q;
  logic [PW-1:0]        prod_p_q;
  logic [55:0]          prod_q_q;
  logic signed [15:0]   est_q;
  logic [16:0]          gain_q;
  logic                 done_q;

  logic [31:0] q_rst [CHANNELS];

  for (genvar g = 0; g < CHANNELS; g++) begin : g_qrst
    assign q_rst[g] = q_reset(g, FRAC_BITS);
  end

  // Handshake and channel range check.
  logic accept, in_range;
  assign accept   = start && (state_q == S_IDLE);
  assign in_range = (32'(channel_i) < 32'(CHANNELS));
  assign busy     = (state_q != S_IDLE);

  // State memories.
  logic        p_we, q_we, mem_re;
  logic [31:0] p_rd, q_rd, p_wdata, q_wdata;

  assign mem_re = accept && in_range;
  assign p_we   = (state_q == S_FIN);
  assign q_we   = (state_q == S_QWR);

  psk_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_p_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (addr_q),
    .wdata_i (p_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(channel_i)),
    .rdata_o (p_rd)
  );

  psk_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_q_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (addr_q),
    .wdata_i (q_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(channel_i)),
    .rdata_o (q_rd)
  );

  // An entry never written reads as its reset value.
  logic [31:0] p_eff, q_eff;
  logic [32:0] pt_sum;
  logic [31:0] pt_c;
  assign p_eff  = p_vld_q[addr_q] ? p_rd : ONE_FX;
  assign q_eff  = q_vld_q[addr_q] ? q_rd : q_rst[addr_q];
  assign pt_sum = {1'b0, p_eff} + {1'b0, q_eff};
  assign pt_c   = pt_sum[32] ? 32'hFFFF_FFFF : pt_sum[31:0];

  // Divider set-up. With no observation noise the gain is exactly one,
  // unless the prediction is zero too, in which case it is zero.
  logic [32:0] denom_c;
  logic        q0_c;
  assign denom_c = {1'b0, pt_q} + {1'b0, obs_q};
  assign q0_c    = (obs_q == 32'd0) && (pt_q != 32'd0);

  // One restoring step of the fractional division per cycle.
  logic [33:0] rem2_c, rem_nx_c;
  logic        ge_c;
  assign rem2_c   = {rem_q[32:0], 1'b0};
  assign ge_c     = (rem2_c >= {1'b0, denom_q});
  assign rem_nx_c = ge_c ? (rem2_c - {1'b0, denom_q}) : rem2_c;

  logic [KW-1:0]      k_c, om_c;
  logic signed [16:0] diff_c;
  assign k_c    = dz_q ? '0 : quo_q;
  assign om_c   = ONE_K - k_c;
  assign diff_c = {raw_q[15], raw_q} - {last_q[15], last_q};

  // Estimate: exact sum, then truncation toward zero.
  logic signed [EW-1:0] total_c, shr_c;
  logic                 adj_c;
  logic signed [15:0]   est_c;
  assign total_c = (EW'(last_q) <<< FRAC_BITS) + prod_e_q;
  assign shr_c   = total_c >>> FRAC_BITS;
  assign adj_c   = total_c[EW-1] && (total_c[FRAC_BITS-1:0] != '0);
  assign est_c   = shr_c[15:0] + {15'd0, adj_c};

  // Covariance and process-noise write-back values.
  logic [55:0] qsh_c;
  assign p_wdata = prod_p_q[FRAC_BITS +: 32];
  assign qsh_c   = prod_q_q >> FRAC_BITS;
  assign q_wdata = (qsh_c[55:32] != '0) ? 32'hFFFF_FFFF : qsh_c[31:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start && in_range) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = kind_q ? S_QWR : S_PREP;
      end
      S_PREP: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == CW'(FRAC_BITS - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      S_QWR: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      obs_q   <= ONE_FX;
      p_vld_q <= '0;
      q_vld_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIN);
      if (noise_we_i) begin
        obs_q <= noise_wdata_i;
      end
      if (state_q == S_PREP) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (p_we) begin
        p_vld_q[addr_q] <= 1'b1;
      end
      if (q_we) begin
        q_vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_q  <= kind_i;
          addr_q  <= AW'(channel_i);
          raw_q   <= raw_sample_i;
          last_q  <= previous_estimate_i;
          ratio_q <= noise_ratio_i;
        end
      end
      S_LOAD: begin
        pt_q     <= pt_c;
        prod_q_q <= 56'(q_eff) * 56'(ratio_q);
      end
      S_PREP: begin
        denom_q <= denom_c;
        dz_q    <= (denom_c == 33'd0);
        rem_q   <= q0_c ? 34'd0 : {2'b00, pt_q};
        quo_q   <= KW'(q0_c);
      end
      S_DIV: begin
        rem_q <= rem_nx_c;
        quo_q <= {quo_q[KW-2:0], ge_c};
      end
      S_MUL: begin
        prod_e_q <= EW'($signed({1'b0, k_c})) * EW'(diff_c);
        prod_p_q <= PW'(om_c) * PW'(pt_q);
      end
      S_FIN: begin
        est_q  <= est_c;
        gain_q <= 17'(k_c);
      end
      default: begin
      end
    endcase
  end

  assign done_o     = done_q;
  assign estimate_o = est_q;
  assign gain_o     = gain_q;

  // A result lasts one cycle and always follows the finishing step.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN))
    else $error("result strobe without a finished sample item");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CW'(FRAC_BITS)))
    else $error("divider step count out of range");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (k_c <= ONE_K))
    else $error("gain above one");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_we && q_we))
    else $error("both state memories written in one cycle");

endmodule
